[rtl/point_in_polygon_test_assert.svh]
// ----------------------------------------------------------------------------
// Point-in-polygon test assertion macros
// Concurrent assertion wrappers on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef POINT_IN_POLYGON_TEST_ASSERT_SVH
`define POINT_IN_POLYGON_TEST_ASSERT_SVH

// same-cycle implication
`define PIP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PIP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/pip_pkg.sv]
// ----------------------------------------------------------------------------
// Point-in-polygon test package
// Shared types, codes and constants of the ray casting block.
// ----------------------------------------------------------------------------
`default_nettype none

package pip_pkg;

  localparam int unsigned MaxVerticesDef = 64;
  localparam int unsigned CoordW         = 16;
  localparam int unsigned CountW         = 7;
  localparam int unsigned IndexW         = 6;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_QUERY = 1'b1
  } pip_kind_e;

  typedef enum logic {
    REG_VERTEX_COUNT = 1'b0,
    REG_NONE         = 1'b1
  } pip_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_HOLD
  } pip_state_e;

  typedef struct packed {
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] x;
  } pip_vertex_t;

  typedef struct packed {
    logic start;
    logic vld;
    logic first;
    logic last;
  } pip_edge_cmd_t;

  typedef struct packed {
    logic              done;
    logic [CountW-1:0] count;
  } pip_edge_res_t;

endpackage

`default_nettype wire

[rtl/point_in_polygon_test.sv]
// Query: the sequencer walks, drains the edge pipeline, then holds the result;
// the walk reads one vertex per cycle from the single memory read port.
// A new query is taken only once the last result is loaded for output; vertex
// writes, one per cycle while idle. Empty polygon: no walk, straight to hold.
// Reset (rst_ni low, asynchronous) clears control and vertex_count; vertex
// memory contents stay undefined until written.
// ----------------------------------------------------------------------------
// Point-in-polygon test
// Holds one polygon in a vertex memory and answers point queries by ray casting.
// ----------------------------------------------------------------------------
`default_nettype none

module point_in_polygon_test #(
  parameter int unsigned MAX_VERTICES = pip_pkg::MaxVerticesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [5:0] vertex_index, [21:6] coord_x, [37:22] coord_y, [39:38] zero
  input  wire logic [39:0] s_axis_tdata,
  // [0] kind
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [0] inside_res, [7:1] crossing_count
  output logic [7:0]       m_axis_tdata,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned AW = $clog2(MAX_VERTICES);

  logic [pip_pkg::CountW-1:0] vcount_q;
  logic m_vld_q;
  logic [7:0] m_data_q;
  pip_pkg::pip_reg_e reg_sel;

  pip_pkg::pip_vertex_t in_coord, rd_data;
  pip_pkg::pip_kind_e in_kind;
  pip_pkg::pip_edge_cmd_t cmd;
  pip_pkg::pip_edge_res_t edge_res, out_load;
  logic wr_en, rd_en, out_free;
  logic [AW-1:0] wr_addr, rd_addr;
  logic signed [pip_pkg::CoordW-1:0] qx, qy;

  assign in_kind    = pip_pkg::pip_kind_e'(s_axis_tuser);
  assign in_coord.x = s_axis_tdata[21:6];
  assign in_coord.y = s_axis_tdata[37:22];
  assign reg_sel    = pip_pkg::pip_reg_e'(paddr[2]);
  assign out_free   = !m_vld_q || m_axis_tready;

  pip_ctrl #(
    .MaxVertices (MAX_VERTICES),
    .AddrW       (AW)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .in_kind_i      (in_kind),
    .in_index_i     (s_axis_tdata[5:0]),
    .in_coord_i     (in_coord),
    .vertex_count_i (vcount_q),
    .out_free_i     (out_free),
    .out_load_o     (out_load),
    .wr_en_o        (wr_en),
    .wr_addr_o      (wr_addr),
    .rd_en_o        (rd_en),
    .rd_addr_o      (rd_addr),
    .cmd_o          (cmd),
    .qx_o           (qx),
    .qy_o           (qy),
    .edge_res_i     (edge_res)
  );

  pip_vtx_mem #(
    .Depth (MAX_VERTICES),
    .AddrW (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (in_coord),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  pip_edge_unit u_edge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .rd_data_i (rd_data),
    .qx_i      (qx),
    .qy_i      (qy),
    .res_o     (edge_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= '0;
      m_vld_q  <= 1'b0;
    end else begin
      if (psel && penable && pwrite && (reg_sel == pip_pkg::REG_VERTEX_COUNT)) begin
        vcount_q <= pwdata[pip_pkg::CountW-1:0];
      end
      if (out_load.done) begin
        m_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load.done) begin
      m_data_q <= {out_load.count, out_load.count[0]};
    end
  end

  always_comb begin
    unique case (reg_sel)
      pip_pkg::REG_VERTEX_COUNT: prdata = 32'(vcount_q);
      default:                   prdata = '0;
    endcase
  end

  assign pready        = 1'b1;
  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = m_data_q;

endmodule

`default_nettype wire

[rtl/pip_vtx_mem.sv]
// ----------------------------------------------------------------------------
// Vertex memory
// One write port and one registered read port holding x and y of each vertex.
// ----------------------------------------------------------------------------
`default_nettype none

module pip_vtx_mem #(
  parameter int unsigned Depth = pip_pkg::MaxVerticesDef,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic               clk_i,
  input  wire logic               wr_en_i,
  input  wire logic [AddrW-1:0]   wr_addr_i,
  input  pip_pkg::pip_vertex_t    wr_data_i,
  input  wire logic               rd_en_i,
  input  wire logic [AddrW-1:0]   rd_addr_i,
  output pip_pkg::pip_vertex_t    rd_data_o
);

  pip_pkg::pip_vertex_t mem_q [Depth];
  pip_pkg::pip_vertex_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

[rtl/pip_edge_unit.sv]
// ----------------------------------------------------------------------------
// Edge crossing pipeline
// Pairs vertices into edges and tests each against the query ray, one per
// cycle, using a cross-multiplied compare in place of the quotient.
// ----------------------------------------------------------------------------
`default_nettype none

`include "point_in_polygon_test_assert.svh"

module pip_edge_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  pip_pkg::pip_edge_cmd_t           cmd_i,
  input  pip_pkg::pip_vertex_t             rd_data_i,
  input  wire logic signed [pip_pkg::CoordW-1:0] qx_i,
  input  wire logic signed [pip_pkg::CoordW-1:0] qy_i,
  output pip_pkg::pip_edge_res_t           res_o
);

  localparam int unsigned CW = pip_pkg::CoordW;
  localparam int unsigned DW = CW + 1;
  localparam int unsigned NW = 2 * DW;
  localparam int unsigned TW = DW + 1;
  localparam int unsigned PW = TW + DW;

  pip_pkg::pip_vertex_t v0_q, prev_q;
  logic wrap_q, wrap_d;

  // edge endpoints
  logic e0_vld_q, e0_vld_d, e0_fin_q, e0_fin_d;
  pip_pkg::pip_vertex_t e0_a_q, e0_a_d, e0_b_q, e0_b_d;

  // differences
  logic e1_vld_q, e1_fin_q, e1_cross_q;
  logic signed [DW-1:0] e1_dx_q, e1_dyq_q, e1_den_q, e1_t_q;

  // numerator product
  logic e2_vld_q, e2_fin_q, e2_cross_q, e2_qneg_q, e2_dneg_q;
  logic signed [NW-1:0] e2_num_q;
  logic signed [DW-1:0] e2_dpos_q;
  logic signed [TW-1:0] e2_tadj_q;

  // compare operands
  logic e3_vld_q, e3_fin_q, e3_cross_q, e3_qneg_q;
  logic signed [PW-1:0] e3_prod_q;
  logic signed [NW-1:0] e3_numn_q;

  logic [pip_pkg::CountW-1:0] cnt_q, cnt_d;
  pip_pkg::pip_edge_res_t res_q;

  logic signed [CW-1:0] ax, ay, bx, by;
  logic                 e1_qneg;
  logic signed [PW-1:0] num_ext;
  logic                 hit;

  always_comb begin
    wrap_d   = wrap_q;
    e0_vld_d = 1'b0;
    e0_fin_d = 1'b0;
    e0_a_d   = prev_q;
    e0_b_d   = rd_data_i;
    if (cmd_i.vld) begin
      e0_vld_d = !cmd_i.first;
      wrap_d   = cmd_i.last;
    end else if (wrap_q) begin
      e0_vld_d = 1'b1;
      e0_fin_d = 1'b1;
      e0_b_d   = v0_q;
      wrap_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.vld) begin
      prev_q <= rd_data_i;
      if (cmd_i.first) begin
        v0_q <= rd_data_i;
      end
    end
    e0_a_d_hold: begin
      e0_a_q <= e0_a_d;
      e0_b_q <= e0_b_d;
    end
  end

  assign ax = $signed(e0_a_q.x);
  assign ay = $signed(e0_a_q.y);
  assign bx = $signed(e0_b_q.x);
  assign by = $signed(e0_b_q.y);

  always_ff @(posedge clk_i) begin
    e1_cross_q <= (ay > qy_i) != (by > qy_i);
    e1_dx_q    <= DW'(bx) - DW'(ax);
    e1_dyq_q   <= DW'(qy_i) - DW'(ay);
    e1_den_q   <= DW'(by) - DW'(ay);
    e1_t_q     <= DW'(qx_i) - DW'(ax);
  end

  assign e1_qneg = (e1_dx_q != '0) && (e1_dyq_q != '0) &&
                   (e1_dx_q[DW-1] ^ e1_dyq_q[DW-1] ^ e1_den_q[DW-1]);

  always_ff @(posedge clk_i) begin
    e2_cross_q <= e1_cross_q;
    e2_num_q   <= e1_dx_q * e1_dyq_q;
    e2_dneg_q  <= e1_den_q[DW-1];
    e2_dpos_q  <= e1_den_q[DW-1] ? -e1_den_q : e1_den_q;
    e2_qneg_q  <= e1_qneg;
    e2_tadj_q  <= e1_qneg ? (TW'(e1_t_q) - TW'(1)) : TW'(e1_t_q);
  end

  always_ff @(posedge clk_i) begin
    e3_cross_q <= e2_cross_q;
    e3_qneg_q  <= e2_qneg_q;
    e3_prod_q  <= e2_tadj_q * e2_dpos_q;
    e3_numn_q  <= e2_dneg_q ? -e2_num_q : e2_num_q;
  end

  assign num_ext = PW'(e3_numn_q);
  assign hit = e3_cross_q && (e3_qneg_q ? (e3_prod_q < num_ext) : (e3_prod_q <= num_ext));

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.start) begin
      cnt_d = '0;
    end else if (e3_vld_q) begin
      cnt_d = cnt_q + pip_pkg::CountW'(hit);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_q   <= 1'b0;
      e0_vld_q <= 1'b0;
      e0_fin_q <= 1'b0;
      e1_vld_q <= 1'b0;
      e1_fin_q <= 1'b0;
      e2_vld_q <= 1'b0;
      e2_fin_q <= 1'b0;
      e3_vld_q <= 1'b0;
      e3_fin_q <= 1'b0;
      cnt_q    <= '0;
      res_q    <= '0;
    end else begin
      wrap_q     <= wrap_d;
      e0_vld_q   <= e0_vld_d;
      e0_fin_q   <= e0_fin_d;
      e1_vld_q   <= e0_vld_q;
      e1_fin_q   <= e0_fin_q;
      e2_vld_q   <= e1_vld_q;
      e2_fin_q   <= e1_fin_q;
      e3_vld_q   <= e2_vld_q;
      e3_fin_q   <= e2_fin_q;
      cnt_q      <= cnt_d;
      res_q.done <= e3_vld_q && e3_fin_q;
      if (e3_vld_q && e3_fin_q) begin
        res_q.count <= cnt_d;
      end
    end
  end

  assign res_o = res_q;

  `PIP_ASSERT_NOW(a_wrap_no_read, wrap_q, !cmd_i.vld, "read data arrived while wrap edge pending")
  `PIP_ASSERT_NEXT(a_done_pulse, res_q.done, !res_q.done, "query done held for two cycles")
  `PIP_ASSERT_NOW(a_start_empty, cmd_i.start,
    !e1_vld_q && !e2_vld_q && !e3_vld_q && !wrap_q, "query started with edges in flight")

endmodule

`default_nettype wire

[rtl/pip_ctrl.sv]
// ----------------------------------------------------------------------------
// Query sequencer
// Takes input words, writes vertices, and walks the vertex memory for queries.
// ----------------------------------------------------------------------------
`default_nettype none

`include "point_in_polygon_test_assert.svh"

module pip_ctrl #(
  parameter int unsigned MaxVertices = pip_pkg::MaxVerticesDef,
  parameter int unsigned AddrW       = $clog2(MaxVertices)
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  pip_pkg::pip_kind_e                     in_kind_i,
  input  wire logic [pip_pkg::IndexW-1:0]        in_index_i,
  input  pip_pkg::pip_vertex_t                   in_coord_i,
  input  wire logic [pip_pkg::CountW-1:0]        vertex_count_i,
  input  wire logic                              out_free_i,
  output pip_pkg::pip_edge_res_t                 out_load_o,
  output logic                                   wr_en_o,
  output logic [AddrW-1:0]                       wr_addr_o,
  output logic                                   rd_en_o,
  output logic [AddrW-1:0]                       rd_addr_o,
  output pip_pkg::pip_edge_cmd_t                 cmd_o,
  output logic signed [pip_pkg::CoordW-1:0]      qx_o,
  output logic signed [pip_pkg::CoordW-1:0]      qy_o,
  input  pip_pkg::pip_edge_res_t                 edge_res_i
);

  localparam int unsigned NW  = $clog2(MaxVertices + 1);
  localparam int unsigned CW  = (NW > pip_pkg::CountW) ? NW : pip_pkg::CountW;
  localparam int unsigned IW  = (NW > pip_pkg::IndexW) ? NW : pip_pkg::IndexW;

  pip_pkg::pip_state_e state_q, state_d;
  logic [AddrW-1:0] rd_idx_q, rd_idx_d, last_q, last_d;
  logic signed [pip_pkg::CoordW-1:0] qx_q, qy_q;
  logic [pip_pkg::CountW-1:0] res_cnt_q, res_cnt_d;
  logic tag_vld_q, tag_first_q, tag_last_q;

  logic accept, query, n_zero;
  logic [CW-1:0] cnt_ext;
  logic [NW-1:0] n_eff;
  logic [IW-1:0] idx_ext;
  logic rd_first, rd_last;

  assign accept  = in_valid_i && in_ready_o;
  assign query   = accept && (in_kind_i == pip_pkg::KIND_QUERY);
  assign cnt_ext = CW'(vertex_count_i);
  assign n_eff   = (cnt_ext > CW'(MaxVertices)) ? NW'(MaxVertices) : NW'(cnt_ext);
  assign n_zero  = (n_eff == '0);
  assign idx_ext = IW'(in_index_i);
  assign rd_first = (rd_idx_q == '0);
  assign rd_last  = (rd_idx_q == last_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pip_pkg::ST_IDLE: begin
        if (query) begin
          state_d = n_zero ? pip_pkg::ST_HOLD : pip_pkg::ST_WALK;
        end
      end
      pip_pkg::ST_WALK: begin
        if (rd_last) begin
          state_d = pip_pkg::ST_DRAIN;
        end
      end
      pip_pkg::ST_DRAIN: begin
        if (edge_res_i.done) begin
          state_d = pip_pkg::ST_HOLD;
        end
      end
      pip_pkg::ST_HOLD: begin
        if (out_free_i) begin
          state_d = pip_pkg::ST_IDLE;
        end
      end
      default: state_d = pip_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o       = (state_q == pip_pkg::ST_IDLE);
    rd_en_o          = (state_q == pip_pkg::ST_WALK);
    out_load_o.done  = (state_q == pip_pkg::ST_HOLD) && out_free_i;
    out_load_o.count = res_cnt_q;
  end

  always_comb begin
    rd_idx_d  = rd_idx_q;
    last_d    = last_q;
    res_cnt_d = res_cnt_q;
    if (query) begin
      rd_idx_d  = '0;
      last_d    = AddrW'(n_eff - NW'(1));
      res_cnt_d = '0;
    end else if (rd_en_o) begin
      rd_idx_d = rd_idx_q + AddrW'(1);
    end
    if (edge_res_i.done) begin
      res_cnt_d = edge_res_i.count;
    end
  end

  assign wr_en_o   = accept && (in_kind_i == pip_pkg::KIND_WRITE) &&
                     (idx_ext < IW'(MaxVertices));
  assign wr_addr_o = idx_ext[AddrW-1:0];
  assign rd_addr_o = rd_idx_q;

  always_ff @(posedge clk_i) begin
    if (query) begin
      qx_q <= $signed(in_coord_i.x);
      qy_q <= $signed(in_coord_i.y);
    end
    last_q      <= last_d;
    res_cnt_q   <= res_cnt_d;
    tag_first_q <= rd_first;
    tag_last_q  <= rd_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pip_pkg::ST_IDLE;
      rd_idx_q  <= '0;
      tag_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_idx_q  <= rd_idx_d;
      tag_vld_q <= rd_en_o;
    end
  end

  assign cmd_o.start = query;
  assign cmd_o.vld   = tag_vld_q;
  assign cmd_o.first = tag_first_q;
  assign cmd_o.last  = tag_last_q;
  assign qx_o        = qx_q;
  assign qy_o        = qy_q;

  `PIP_ASSERT_NOW(a_walk_bound, state_q == pip_pkg::ST_WALK, rd_idx_q <= last_q,
    "read address ran past the last vertex")
  `PIP_ASSERT_NOW(a_done_in_drain, edge_res_i.done, state_q == pip_pkg::ST_DRAIN,
    "edge result outside drain")
  `PIP_ASSERT_NEXT(a_hold_release, (state_q == pip_pkg::ST_HOLD) && out_free_i,
    state_q == pip_pkg::ST_IDLE, "result handed over but sequencer not idle")

endmodule

`default_nettype wire
